// ----- rtl/core/sip_pkg.sv -----
// Shared types, constants and command codes for the section interval profiler.
package sip_pkg;

  localparam int unsigned SECTIONS = 8;
  localparam int unsigned SecAw = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  typedef enum logic [2:0] {
    CmdBegin   = 3'd0,
    CmdEnd     = 3'd1,
    CmdPoint   = 3'd2,
    CmdRearm   = 3'd3,
    CmdClear   = 3'd4,
    CmdSetMode = 3'd5,
    CmdDump    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StEndSub,
    StEndWr,
    StDump
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  section;
    logic [63:0] timestamp;
    logic [7:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_section;
    logic [31:0] interval_count;
    logic [63:0] tick_total;
    logic [63:0] tick_min;
    logic [63:0] tick_max;
    logic [31:0] sweeps;
    logic [31:0] points;
    logic [31:0] rearms;
    logic        is_enabled;
    logic [7:0]  out_mode;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] tick_min;
    logic [63:0] tick_max;
  } stats_t;

  localparam int unsigned StatsW = $bits(stats_t);

endpackage

// ----- rtl/core/sip_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module sip_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/section_interval_profiler.sv -----
// Top level of the section interval profiler: command decode, statistics update and dump.
// Begin, note, clear and set-mode items leave busy low, so the next item can follow straight away.
// End on an active section holds busy in StEndSub and StEndWr (read, subtract, update).
// Dump holds busy in StDump (one statistics memory read per section); each record passes the RAM
// read register and the output register before its strobe, one per cycle, last flag on the final.
// Reset clears all counters, active marks and per-section valid bits at once; no clearing pass.
module section_interval_profiler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sip_pkg::in_item_t  item_i,
  output logic               result_strobe_o,
  output sip_pkg::out_item_t result_o
);

  // Section state lives in two memories: the start timestamps and the statistics
  // record (count, total, min, max). A statistics entry counts as zero until it is
  // first written after reset or a clear; that is tracked by one valid bit per
  // section, so a clear needs no pass over the memory. Start timestamps need no
  // valid bit, as they are only read for a section whose active mark is set, and
  // that mark is only set by a begin which writes the timestamp.

  sip_pkg::state_e state_q, state_d;

  logic [sip_pkg::SECTIONS-1:0] active_q, active_d;
  logic [sip_pkg::SECTIONS-1:0] vld_q, vld_d;

  logic [31:0] sweeps_q, sweeps_d;
  logic [31:0] points_q, points_d;
  logic [31:0] rearms_q, rearms_d;
  logic        enabled_q, enabled_d;
  logic [7:0]  mode_q, mode_d;

  // End-command working registers.
  logic [sip_pkg::SecAw-1:0] sec_q, sec_d;
  logic [63:0]               ts_q, ts_d;
  logic [63:0]               elapsed_q, elapsed_d;

  // Dump sequencing: idx_q walks the read address, rd_* tracks the read in flight.
  logic [sip_pkg::SecAw-1:0] idx_q, idx_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [sip_pkg::SecAw-1:0] rd_idx_q, rd_idx_d;

  sip_pkg::out_item_t out_q, out_d;
  logic               out_vld_q, out_vld_d;

  // Memory ports.
  logic                      start_we;
  logic [sip_pkg::SecAw-1:0] start_waddr;
  logic                      start_re;
  logic [sip_pkg::SecAw-1:0] start_raddr;
  logic [63:0]               start_rdata;

  logic                      stats_we;
  logic [sip_pkg::SecAw-1:0] stats_waddr;
  sip_pkg::stats_t           stats_wdata;
  logic                      stats_re;
  logic [sip_pkg::SecAw-1:0] stats_raddr;
  logic [sip_pkg::StatsW-1:0] stats_rdata;

  logic                      accept;
  logic                      in_range;
  logic [sip_pkg::SecAw-1:0] sec_addr;

  // Statistics update for an end item.
  sip_pkg::stats_t cur_stats;
  sip_pkg::stats_t new_stats;
  sip_pkg::stats_t dump_stats;

  assign busy     = (state_q != sip_pkg::StIdle);
  assign accept   = start && !busy;
  assign in_range = (32'(item_i.section) < 32'(sip_pkg::SECTIONS));
  assign sec_addr = sip_pkg::SecAw'(item_i.section);

  sip_ram #(
    .Width(64),
    .Depth(sip_pkg::SECTIONS)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (start_we),
    .waddr_i(start_waddr),
    .wdata_i(ts_d),
    .re_i   (start_re),
    .raddr_i(start_raddr),
    .rdata_o(start_rdata)
  );

  sip_ram #(
    .Width(sip_pkg::StatsW),
    .Depth(sip_pkg::SECTIONS)
  ) u_stats_ram (
    .clk_i  (clk_i),
    .we_i   (stats_we),
    .waddr_i(stats_waddr),
    .wdata_i(stats_wdata),
    .re_i   (stats_re),
    .raddr_i(stats_raddr),
    .rdata_o(stats_rdata)
  );

  // The statistics read data of an end item is consumed in StEndWr. An entry that has
  // not been written since the last clear reads as all zero. The first sample after
  // reset, after a clear or after the count wraps round sees a new count of one and
  // so takes over the minimum unconditionally.
  always_comb begin
    cur_stats          = vld_q[sec_q] ? sip_pkg::stats_t'(stats_rdata) : '0;
    new_stats.count    = cur_stats.count + 32'd1;
    new_stats.total    = cur_stats.total + elapsed_q;
    new_stats.tick_min = ((new_stats.count == 32'd1) || (elapsed_q < cur_stats.tick_min)) ?
                         elapsed_q : cur_stats.tick_min;
    new_stats.tick_max = (elapsed_q > cur_stats.tick_max) ? elapsed_q : cur_stats.tick_max;
  end

  // Dump records are assembled from the read data in the cycle after each read. The global
  // counters cannot change while the dump reads are issued, as busy is high; the final
  // record is latched at the same edge as any item accepted right after the dump, so it
  // still carries the values from before that item.
  always_comb begin
    dump_stats               = vld_q[rd_idx_q] ? sip_pkg::stats_t'(stats_rdata) : '0;
    out_d                    = out_q;
    out_vld_d                = rd_vld_q;
    if (rd_vld_q) begin
      out_d.out_section    = 3'(rd_idx_q);
      out_d.interval_count = dump_stats.count;
      out_d.tick_total     = dump_stats.total;
      out_d.tick_min       = dump_stats.tick_min;
      out_d.tick_max       = dump_stats.tick_max;
      out_d.sweeps         = sweeps_q;
      out_d.points         = points_q;
      out_d.rearms         = rearms_q;
      out_d.is_enabled     = enabled_q;
      out_d.out_mode       = mode_q;
      out_d.last           = (rd_idx_q == sip_pkg::SecAw'(sip_pkg::SECTIONS - 1));
    end
  end

  // Command decode and sequencing.
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    vld_d       = vld_q;
    sweeps_d    = sweeps_q;
    points_d    = points_q;
    rearms_d    = rearms_q;
    enabled_d   = enabled_q;
    mode_d      = mode_q;
    sec_d       = sec_q;
    ts_d        = ts_q;
    elapsed_d   = elapsed_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;

    start_we    = 1'b0;
    start_waddr = sec_addr;
    start_re    = 1'b0;
    start_raddr = sec_addr;
    stats_we    = 1'b0;
    stats_waddr = sec_q;
    stats_wdata = new_stats;
    stats_re    = 1'b0;
    stats_raddr = sec_addr;

    case (state_q)
      sip_pkg::StIdle: begin
        if (accept) begin
          case (item_i.cmd)
            sip_pkg::CmdBegin: begin
              if (in_range) begin
                // A begin on an active section simply restarts its interval.
                ts_d               = item_i.timestamp;
                start_we           = 1'b1;
                active_d[sec_addr] = 1'b1;
              end
            end
            sip_pkg::CmdEnd: begin
              // An end on an inactive or out-of-range section is dropped here.
              if (in_range && active_q[sec_addr]) begin
                sec_d    = sec_addr;
                ts_d     = item_i.timestamp;
                start_re = 1'b1;
                stats_re = 1'b1;
                state_d  = sip_pkg::StEndSub;
              end
            end
            sip_pkg::CmdPoint: begin
              points_d = points_q + 32'd1;
            end
            sip_pkg::CmdRearm: begin
              rearms_d = rearms_q + 32'd1;
            end
            sip_pkg::CmdClear: begin
              active_d  = '0;
              vld_d     = '0;
              points_d  = '0;
              rearms_d  = '0;
              sweeps_d  = 32'd1;
              enabled_d = 1'b1;
              mode_d    = item_i.mode;
            end
            sip_pkg::CmdSetMode: begin
              enabled_d = 1'b1;
              mode_d    = item_i.mode;
            end
            sip_pkg::CmdDump: begin
              idx_d   = '0;
              state_d = sip_pkg::StDump;
            end
            default: begin
            end
          endcase
        end
      end

      sip_pkg::StEndSub: begin
        // Elapsed time wraps modulo 2^64.
        elapsed_d = ts_q - start_rdata;
        state_d   = sip_pkg::StEndWr;
      end

      sip_pkg::StEndWr: begin
        stats_we        = 1'b1;
        vld_d[sec_q]    = 1'b1;
        active_d[sec_q] = 1'b0;
        state_d         = sip_pkg::StIdle;
      end

      sip_pkg::StDump: begin
        stats_re    = 1'b1;
        stats_raddr = idx_q;
        rd_vld_d    = 1'b1;
        rd_idx_d    = idx_q;
        if (idx_q == sip_pkg::SecAw'(sip_pkg::SECTIONS - 1)) begin
          state_d = sip_pkg::StIdle;
        end else begin
          idx_d = idx_q + sip_pkg::SecAw'(1);
        end
      end

      default: begin
        state_d = sip_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sip_pkg::StIdle;
      active_q  <= '0;
      vld_q     <= '0;
      sweeps_q  <= '0;
      points_q  <= '0;
      rearms_q  <= '0;
      enabled_q <= 1'b0;
      mode_q    <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      vld_q     <= vld_d;
      sweeps_q  <= sweeps_d;
      points_q  <= points_d;
      rearms_q  <= rearms_d;
      enabled_q <= enabled_d;
      mode_q    <= mode_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    sec_q     <= sec_d;
    ts_q      <= ts_d;
    elapsed_q <= elapsed_d;
    rd_idx_q  <= rd_idx_d;
    out_q     <= out_d;
  end

  assign result_strobe_o = out_vld_q;
  assign result_o        = out_q;

endmodule

// ----- sim/tb_section_interval_profiler.sv -----
// Self-checking testbench for the section interval profiler: directed and random items.
`timescale 1ns / 1ps

module tb_section_interval_profiler;
  import sip_pkg::*;

  // cmd 7 is not decoded by the block; it must be ignored without a record.
  localparam logic [2:0]  CmdUnused = 3'd7;
  localparam int unsigned RandomItems = 88;
  // A dump's final record and an end's busy period both fall well within SettleCycles.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } plan_entry_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  cmd_item;
  logic      result_strobe_o;
  out_item_t result_o;

  section_interval_profiler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (cmd_item),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  // Items waiting to be offered, and the dump records still owed by the block.
  plan_entry_t cmd_plan_q[$];
  out_item_t   dump_records_q[$];

  // Shadow copy of the profiler state, updated as each item is accepted.
  logic [63:0] begin_stamp [SECTIONS];
  logic        running     [SECTIONS];
  logic [31:0] done_count  [SECTIONS];
  logic [63:0] sum_ticks   [SECTIONS];
  logic [63:0] shortest    [SECTIONS];
  logic [63:0] longest     [SECTIONS];
  logic [31:0] sweep_cnt;
  logic [31:0] point_cnt;
  logic [31:0] rearm_cnt;
  logic        enabled;
  logic [7:0]  mode_byte;

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_cnt = 0;
  int unsigned burst_left = 0;
  logic        sent = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void wipe_stats();
    for (int s = 0; s < SECTIONS; s++) begin
      begin_stamp[s] = '0;
      running[s]     = 1'b0;
      done_count[s]  = '0;
      sum_ticks[s]   = '0;
      shortest[s]    = '0;
      longest[s]     = '0;
    end
    sweep_cnt = '0;
    point_cnt = '0;
    rearm_cnt = '0;
    enabled   = 1'b0;
    mode_byte = '0;
  endfunction

  // Applies one accepted item to the shadow state; a dump queues one record per section,
  // each carrying the global counters as they stand when the dump is accepted.
  function automatic void profile_step(in_item_t it);
    logic [63:0] elapsed;
    out_item_t   rec;
    case (it.cmd)
      CmdBegin: begin
        if (it.section < SECTIONS) begin
          begin_stamp[it.section] = it.timestamp;
          running[it.section]     = 1'b1;
        end
      end
      CmdEnd: begin
        // An end with no open interval leaves everything untouched.
        if (it.section < SECTIONS && running[it.section]) begin
          elapsed = it.timestamp - begin_stamp[it.section];
          done_count[it.section] = done_count[it.section] + 32'd1;
          sum_ticks[it.section]  = sum_ticks[it.section] + elapsed;
          // The first sample after a clear, or after the count wraps round, sets the minimum.
          if (done_count[it.section] == 32'd1 || elapsed < shortest[it.section]) begin
            shortest[it.section] = elapsed;
          end
          if (elapsed > longest[it.section]) begin
            longest[it.section] = elapsed;
          end
          running[it.section] = 1'b0;
        end
      end
      CmdPoint: point_cnt = point_cnt + 32'd1;
      CmdRearm: rearm_cnt = rearm_cnt + 32'd1;
      CmdClear: begin
        wipe_stats();
        sweep_cnt = 32'd1;
        enabled   = 1'b1;
        mode_byte = it.mode;
      end
      CmdSetMode: begin
        enabled   = 1'b1;
        mode_byte = it.mode;
      end
      CmdDump: begin
        for (int s = 0; s < SECTIONS; s++) begin
          rec.out_section    = 3'(s);
          rec.interval_count = done_count[s];
          rec.tick_total     = sum_ticks[s];
          rec.tick_min       = shortest[s];
          rec.tick_max       = longest[s];
          rec.sweeps         = sweep_cnt;
          rec.points         = point_cnt;
          rec.rearms         = rearm_cnt;
          rec.is_enabled     = enabled;
          rec.out_mode       = mode_byte;
          rec.last           = (s == SECTIONS - 1);
          dump_records_q.push_back(rec);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one, and occasional runs with none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(8, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void plan_cmd(logic [2:0] cmd, logic [2:0] sec, logic [63:0] ts,
                                   logic [7:0] md);
    plan_entry_t e;
    e.item.cmd       = cmd;
    e.item.section   = sec;
    e.item.timestamp = ts;
    e.item.mode      = md;
    e.gap            = pick_gap();
    e.drain          = 1'b0;
    cmd_plan_q.push_back(e);
  endfunction

  // A marker that holds the sender back until every owed record has arrived.
  function automatic void plan_drain();
    plan_entry_t e;
    e.item  = '0;
    e.gap   = 0;
    e.drain = 1'b1;
    cmd_plan_q.push_back(e);
  endfunction

  // Driver: offers the head of the plan at the falling edge and holds it until accepted.
  // start and cmd_item each get exactly one nonblocking update per falling edge; start stays low
  // until reset has been released.
  always @(negedge clk_i) begin : drive
    logic        nxt_start;
    in_item_t    nxt_item;
    plan_entry_t entry;
    nxt_start = (rst_ni === 1'b1) && start && !sent;
    nxt_item  = cmd_item;
    if (!nxt_start && rst_ni) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (cmd_plan_q.size() > 0) begin
        if (!(cmd_plan_q[0].drain && (dump_records_q.size() != 0 || busy))) begin
          entry = cmd_plan_q.pop_front();
          if (!entry.drain) begin
            nxt_start = 1'b1;
            nxt_item  = entry.item;
            gap_cnt  <= entry.gap;
          end
        end
      end
    end
    start    <= nxt_start;
    cmd_item <= nxt_item;
  end

  // Monitor: takes accepted items into the shadow state and checks each strobed record
  // against the oldest one owed. It also runs the watchdog on cycles with no traffic.
  always @(posedge clk_i) begin : observe
    out_item_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        profile_step(cmd_item);
      end
      if (result_strobe_o) begin
        if (dump_records_q.size() == 0) begin
          $error("record for section %0d with none owed", result_o.out_section);
          error_count++;
        end else begin
          want = dump_records_q.pop_front();
          compare_field("out_section", 64'(want.out_section), 64'(result_o.out_section));
          compare_field("interval_count", 64'(want.interval_count),
                        64'(result_o.interval_count));
          compare_field("tick_total", want.tick_total, result_o.tick_total);
          compare_field("tick_min", want.tick_min, result_o.tick_min);
          compare_field("tick_max", want.tick_max, result_o.tick_max);
          compare_field("sweeps", 64'(want.sweeps), 64'(result_o.sweeps));
          compare_field("points", 64'(want.points), 64'(result_o.points));
          compare_field("rearms", 64'(want.rearms), 64'(result_o.rearms));
          compare_field("is_enabled", 64'(want.is_enabled), 64'(result_o.is_enabled));
          compare_field("out_mode", 64'(want.out_mode), 64'(result_o.out_mode));
          compare_field("last", 64'(want.last), 64'(result_o.last));
        end
      end
      if ((start && !busy) || result_strobe_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WatchdogLimit) begin
        $display("tb_section_interval_profiler: done, errors");
        $finish;
      end
    end
    sent <= rst_ni && start && !busy;
  end

  initial begin : stimulus
    logic [63:0] tick;
    logic [2:0]  sec;
    logic [7:0]  open_mask;
    int unsigned sel;
    start    = 1'b0;
    cmd_item = '0;
    rst_ni   = 1'b0;
    wipe_stats();

    // Directed part. A dump straight after reset shows every statistic at zero.
    plan_cmd(CmdDump, 3'd0, rnd64(), 8'($urandom));
    // End with no begin is ignored.
    plan_cmd(CmdEnd, 3'd2, rnd64(), 8'($urandom));
    // Widest possible interval, then one that wraps through zero.
    plan_cmd(CmdBegin, 3'd0, 64'h0, 8'($urandom));
    plan_cmd(CmdEnd, 3'd0, '1, 8'($urandom));
    plan_cmd(CmdBegin, 3'd1, '1, 8'($urandom));
    plan_cmd(CmdEnd, 3'd1, 64'd5, 8'($urandom));
    // A repeated begin restarts the interval; a second, shorter sample lowers the minimum.
    plan_cmd(CmdBegin, 3'd3, 64'd100, 8'($urandom));
    plan_cmd(CmdBegin, 3'd3, 64'd200, 8'($urandom));
    plan_cmd(CmdEnd, 3'd3, 64'd250, 8'($urandom));
    plan_cmd(CmdBegin, 3'd3, 64'd0, 8'($urandom));
    plan_cmd(CmdEnd, 3'd3, 64'd10, 8'($urandom));
    // A zero-length interval on the top section.
    plan_cmd(CmdBegin, 3'd7, 64'h0123_4567_89ab_cdef, 8'($urandom));
    plan_cmd(CmdEnd, 3'd7, 64'h0123_4567_89ab_cdef, 8'($urandom));
    plan_cmd(CmdPoint, 3'($urandom), rnd64(), 8'($urandom));
    plan_cmd(CmdRearm, 3'($urandom), rnd64(), 8'($urandom));
    plan_cmd(CmdSetMode, 3'($urandom), rnd64(), 8'hff);
    plan_cmd(CmdUnused, 3'($urandom), rnd64(), 8'($urandom));
    plan_cmd(CmdDump, 3'($urandom), rnd64(), 8'($urandom));
    // Clear with an open interval: the mark must go, so the following end is ignored.
    plan_cmd(CmdBegin, 3'd5, 64'd1000, 8'($urandom));
    plan_cmd(CmdClear, 3'($urandom), rnd64(), 8'ha5);
    plan_cmd(CmdEnd, 3'd5, 64'd2000, 8'($urandom));
    plan_cmd(CmdDump, 3'($urandom), rnd64(), 8'($urandom));
    plan_drain();

    // Random part: mostly begin/end pairs on a running tick, with notes, mode changes,
    // clears, dumps and stray ends mixed in. The tick sometimes jumps anywhere.
    tick      = rnd64();
    open_mask = '0;
    for (int n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 99);
      sec = 3'($urandom_range(0, SECTIONS - 1));
      if ($urandom_range(0, 19) == 0) begin
        tick = rnd64();
      end else begin
        tick = tick + $urandom_range(0, 2000);
      end
      if (n == RandomItems / 2) begin
        plan_drain();
      end
      if (sel < 36) begin
        plan_cmd(CmdBegin, sec, tick, 8'($urandom));
        open_mask[sec] = 1'b1;
      end else if (sel < 70) begin
        if (open_mask != '0 && $urandom_range(0, 9) != 0) begin
          while (!open_mask[sec]) sec = 3'($urandom_range(0, SECTIONS - 1));
        end
        plan_cmd(CmdEnd, sec, tick, 8'($urandom));
        open_mask[sec] = 1'b0;
      end else if (sel < 76) begin
        plan_cmd(CmdPoint, sec, rnd64(), 8'($urandom));
      end else if (sel < 82) begin
        plan_cmd(CmdRearm, sec, rnd64(), 8'($urandom));
      end else if (sel < 86) begin
        plan_cmd(CmdSetMode, sec, rnd64(), 8'($urandom));
      end else if (sel < 88) begin
        plan_cmd(CmdClear, sec, rnd64(), 8'($urandom));
        open_mask = '0;
      end else if (sel < 96) begin
        plan_cmd(CmdDump, sec, rnd64(), 8'($urandom));
      end else if (sel < 98) begin
        plan_cmd(CmdUnused, sec, rnd64(), 8'($urandom));
      end else begin
        plan_cmd(CmdBegin, sec, rnd64(), 8'($urandom));
        open_mask[sec] = 1'b1;
      end
    end
    plan_cmd(CmdDump, 3'($urandom), rnd64(), 8'($urandom));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the plan to run dry and every owed record to arrive, then let the block settle.
    while (cmd_plan_q.size() != 0 || start || dump_records_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_section_interval_profiler: done, clean");
    end else begin
      $display("tb_section_interval_profiler: done, errors");
    end
    $finish;
  end

endmodule

// ----- section_interval_profiler.f -----
rtl/core/sip_pkg.sv
rtl/core/sip_ram.sv
rtl/core/section_interval_profiler.sv
sim/tb_section_interval_profiler.sv
